### design/fifo_handoff_lock_unit_macros.svh
// ----------------------------------------------------------------------------
// FIFO handoff lock unit assertion macros
// Concurrent assertion helpers shared by the lock unit modules. They are
// empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FIFO_HANDOFF_LOCK_UNIT_MACROS_SVH
`define FIFO_HANDOFF_LOCK_UNIT_MACROS_SVH

`ifndef SYNTH

// Condition that must hold at every clock edge outside reset.
`define FHL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define FHL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FHL_ASSERT_ALWAYS(lbl, cond, msg)
`define FHL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### design/fhl_pkg.sv
// ----------------------------------------------------------------------------
// FIFO handoff lock unit package
// Sizes, operation codes and the beat structures shared by the lock modules.
// ----------------------------------------------------------------------------
package fhl_pkg;

  // Queue and identity sizes.
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

  // Field widths of the stream beats.
  localparam int FUNC_W = 2;
  localparam int RID_W  = 8;

  typedef logic [ID_BITS-1:0]  id_t;
  typedef logic [PTR_BITS-1:0] ptr_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TRY_LOCK = 2'd0,
    FUNC_ACQUIRE  = 2'd1,
    FUNC_UNLOCK   = 2'd2
  } func_t;

  // One operation beat.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [RID_W-1:0]  requester_id;
  } fhl_op_t;

  // One result beat.
  typedef struct packed {
    logic             lock_held;
    logic [RID_W-1:0] resume_id;
    logic             resume_valid;
    logic             overflow;
    logic             self_wait;
    logic             queued;
    logic             granted;
  } fhl_result_t;

  // Slot behind the newest waiter; the sum stays below twice the depth.
  function automatic ptr_t ptr_tail(input ptr_t head, input cnt_t count);
    logic [CNT_BITS:0] sum;
    sum = (CNT_BITS + 1)'(head) + (CNT_BITS + 1)'(count);
    if (sum >= (CNT_BITS + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_BITS + 1)'(QUEUE_DEPTH);
    end
    return PTR_BITS'(sum);
  endfunction

  // Advance a queue pointer with wraparound.
  function automatic ptr_t ptr_inc(input ptr_t ptr);
    ptr_t res;
    if (ptr == PTR_BITS'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PTR_BITS'(1);
    end
    return res;
  endfunction

endpackage

### design/fifo_handoff_lock_unit.sv
// ----------------------------------------------------------------------------
// FIFO handoff lock unit
// Fair lock with a FIFO of waiting requester IDs and direct handoff on
// unlock. One operation beat in gives one result beat out.
//
//   Channel  Direction  Beat contents
//   s_axis   in         tuser: func; tdata: requester_id
//   m_axis   out        tdata: granted, queued, self_wait, overflow,
//                              resume_valid, resume_id, lock_held
//
// An operation is applied in the cycle it is accepted; its result is
// registered into the result buffer and shown on the master side from there.
// One operation per cycle is sustained while the result buffer has room,
// updating the lock state and the head and tail slots of the waiter queue.
// Synchronous reset frees the lock and empties the queue at once.
// A two-entry result buffer lets one beat be accepted while a result waits;
// s_tready drops only when both entries are occupied.
// ----------------------------------------------------------------------------
module fifo_handoff_lock_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] requester_id
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] granted, [1] queued, [2] self_wait,
                                 // [3] overflow, [4] resume_valid,
                                 // [12:5] resume_id, [13] lock_held, [15:14] zero
);
  import fhl_pkg::*;

  fhl_op_t     op;
  fhl_result_t core_res;
  fhl_result_t out_res;
  logic        fire;

  assign op.func         = s_tuser;
  assign op.requester_id = s_tdata;
  assign fire            = s_tvalid && s_tready;

  // Lock state and waiter queue.
  fhl_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .op   (op),
    .res  (core_res)
  );

  // Result buffer toward the master side.
  fhl_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (core_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  // Pack the result beat, first field in the lowest bit.
  assign m_tdata = {2'b00, out_res.lock_held, out_res.resume_id, out_res.resume_valid,
                    out_res.overflow, out_res.self_wait, out_res.queued, out_res.granted};

endmodule

### design/fhl_core.sv
// ----------------------------------------------------------------------------
// FIFO handoff lock core
// Lock state, holder identity and the circular waiter queue. Each accepted
// operation is decoded and applied in the cycle it is accepted.
// ----------------------------------------------------------------------------
module fhl_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  fhl_pkg::fhl_op_t    op,
  output fhl_pkg::fhl_result_t res
);
  import fhl_pkg::*;

  `include "fifo_handoff_lock_unit_macros.svh"

  logic held;
  logic held_next;
  id_t  holder;
  id_t  holder_next;
  ptr_t head;
  ptr_t head_next;
  cnt_t count;
  cnt_t count_next;
  logic wr_en;
  logic rd_en;
  ptr_t tail;
  id_t  id;
  id_t  head_id;

  id_t queue [QUEUE_DEPTH];

  // The requester ID is taken to the identity width.
  assign id      = ID_BITS'(op.requester_id);
  assign tail    = ptr_tail(head, count);

  // Decode the operation against the current lock state.
  always_comb begin
    held_next   = held;
    holder_next = holder;
    head_next   = head;
    count_next  = count;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    res         = '0;
    case (op.func)
      FUNC_TRY_LOCK: begin
        if (!held) begin
          held_next   = 1'b1;
          holder_next = '0;
          res.granted = 1'b1;
        end
      end
      FUNC_ACQUIRE: begin
        if (!held) begin
          held_next   = 1'b1;
          holder_next = id;
          res.granted = 1'b1;
        end else begin
          if (holder != '0 && holder == id) begin
            res.self_wait = 1'b1;
          end
          if (count == CNT_FULL) begin
            res.overflow = 1'b1;
          end else begin
            wr_en      = fire;
            count_next = count + CNT_BITS'(1);
            res.queued = 1'b1;
          end
        end
      end
      FUNC_UNLOCK: begin
        if (count == '0) begin
          held_next   = 1'b0;
          holder_next = '0;
        end else begin
          rd_en            = fire;
          head_next        = ptr_inc(head);
          count_next       = count - CNT_BITS'(1);
          holder_next      = head_id;
          res.resume_valid = 1'b1;
          res.resume_id    = RID_W'(head_id);
        end
      end
      default: begin
      end
    endcase
    res.lock_held = held_next;
  end

  // Lock state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= 1'b0;
      holder <= '0;
      head   <= '0;
      count  <= '0;
    end else if (fire) begin
      held   <= held_next;
      holder <= holder_next;
      head   <= head_next;
      count  <= count_next;
    end
  end

  // Waiter queue storage, written at the tail.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue[tail] <= id;
    end
  end

  // Oldest waiter, held in a register. A push into an empty queue lands here
  // directly; a pop loads the entry behind the old head.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_id <= '0;
    end else if (wr_en && count == '0) begin
      head_id <= id;
    end else if (rd_en) begin
      head_id <= queue[ptr_inc(head)];
    end
  end

  `FHL_ASSERT_ALWAYS(a_count_bound, count <= CNT_FULL, "waiter count exceeds queue depth")
  `FHL_ASSERT_ALWAYS(a_waiters_need_holder, (count == '0) || held, "waiters queued on a free lock")
  `FHL_ASSERT_NEXT(a_handoff_keeps_lock, fire && op.func == FUNC_UNLOCK && count != '0, held && count == $past(count) - CNT_BITS'(1), "handoff did not keep the lock held")
  `FHL_ASSERT_NEXT(a_acquire_records_holder, fire && op.func == FUNC_ACQUIRE && !held, held && holder == $past(id), "free acquire did not record its holder")

endmodule

### design/fhl_skid.sv
// ----------------------------------------------------------------------------
// FIFO handoff lock result buffer
// Two-entry output buffer so that a new beat can be taken while a finished
// result waits on the master side.
// ----------------------------------------------------------------------------
module fhl_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fhl_pkg::fhl_result_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fhl_pkg::fhl_result_t out_data
);
  import fhl_pkg::*;

  `include "fifo_handoff_lock_unit_macros.svh"

  logic [1:0]  fill;
  fhl_result_t slot0;
  fhl_result_t slot1;
  logic        push;
  logic        pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = slot0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (push && !pop) begin
      fill <= fill + 2'd1;
    end else if (pop && !push) begin
      fill <= fill - 2'd1;
    end
  end

  // Result slots; the oldest result always sits in slot 0.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push) begin
        if (fill == 2'd1) begin
          slot0 <= in_data;
        end else begin
          slot0 <= slot1;
          slot1 <= in_data;
        end
      end else begin
        slot0 <= slot1;
      end
    end else if (push) begin
      if (fill == 2'd0) begin
        slot0 <= in_data;
      end else begin
        slot1 <= in_data;
      end
    end
  end

  `FHL_ASSERT_ALWAYS(a_fill_bound, fill <= 2'd2, "result buffer fill out of range")
  `FHL_ASSERT_NEXT(a_full_holds_head, fill == 2'd2 && !out_ready, fill == 2'd2 && slot0 == $past(slot0), "full buffer lost its oldest result")

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// FIFO handoff lock unit testbench
// Drives lock operations into the slave stream. A behavioral model of the
// lock, its holder and its waiter FIFO predicts each result beat. Every beat
// on the master stream is compared field by field with the oldest
// prediction. Both stream sides idle and stall at random but in the last
// phase. The run includes a long receiver stall that fills the block, and a
// sender pause that lets the block drain.
// ----------------------------------------------------------------------------
module testbench;
  import fhl_pkg::*;

  // Operation code that the block treats as a no-op.
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int LOG_LIMIT = 40;
  localparam int PHASE_ITEMS = 365;

  // Lock model and the store of predicted result beats.
  class lock_scoreboard;
    bit          held;
    id_t         holder;
    id_t         waiters [QUEUE_DEPTH];
    int          head;
    int          count;
    fhl_result_t expected_q[$];
    int          errors;

    function new();
      held   = 1'b0;
      holder = '0;
      head   = 0;
      count  = 0;
      errors = 0;
      foreach (waiters[i]) waiters[i] = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted operation to the model and queue its result.
    function void note_op(input logic [FUNC_W-1:0] f, input id_t id);
      fhl_result_t r;
      r = '0;
      case (f)
        FUNC_TRY_LOCK: begin
          // A lock taken this way has no known holder.
          if (!held) begin
            held      = 1'b1;
            holder    = '0;
            r.granted = 1'b1;
          end
        end
        FUNC_ACQUIRE: begin
          if (!held) begin
            held      = 1'b1;
            holder    = id;
            r.granted = 1'b1;
          end else begin
            if (holder != '0 && holder == id) r.self_wait = 1'b1;
            if (count >= QUEUE_DEPTH) begin
              r.overflow = 1'b1;
            end else begin
              waiters[(head + count) % QUEUE_DEPTH] = id;
              count++;
              r.queued = 1'b1;
            end
          end
        end
        FUNC_UNLOCK: begin
          // Hand the lock to the oldest waiter, or free it.
          if (count == 0) begin
            held   = 1'b0;
            holder = '0;
          end else begin
            holder         = waiters[head];
            r.resume_id    = waiters[head];
            r.resume_valid = 1'b1;
            head           = (head + 1) % QUEUE_DEPTH;
            count--;
          end
        end
        default: ;
      endcase
      r.lock_held = held;
      expected_q = {expected_q, r};
    endfunction

    task report(input string msg);
      if (errors < LOG_LIMIT) $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report($sformatf("%s is %0h, predicted %0h", name, got, want));
    endtask

    // Compare one accepted result beat with the oldest prediction.
    task check_result(input logic [15:0] data);
      fhl_result_t got;
      fhl_result_t want;
      got = data[13:0];
      if (expected_q.size() == 0) begin
        report($sformatf("result beat %h arrived with nothing predicted", data));
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      compare("granted", got.granted, want.granted);
      compare("queued", got.queued, want.queued);
      compare("self_wait", got.self_wait, want.self_wait);
      compare("overflow", got.overflow, want.overflow);
      compare("resume_valid", got.resume_valid, want.resume_valid);
      compare("resume_id", got.resume_id, want.resume_id);
      compare("lock_held", got.lock_held, want.lock_held);
      compare("padding", data[15:14], 2'b00);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_cycles;

  lock_scoreboard sb = new();

  fifo_handoff_lock_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rx_hold_cycles > 0) begin
      m_tready       <= 1'b0;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: note each accepted operation beat and check each result beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_op(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // Offer one operation beat, with random gaps, and wait until it is taken.
  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [7:0] id);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= id;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering and wait until every predicted result has been seen.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly a small pool of IDs so that self-waits and repeats are frequent.
  function automatic logic [7:0] pick_id();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 8'($urandom_range(6, 1));
    if (roll < 63) return 8'h00;
    return 8'($urandom_range(255));
  endfunction

  // Random operations in stretches that alternately fill and drain the queue.
  task automatic run_phase(input int n_items);
    int k;
    int roll;
    int fill_pct;
    int unlock_pct;
    logic [FUNC_W-1:0] f;
    fill_pct   = 70;
    unlock_pct = 15;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) begin
        fill_pct   = ((k / 40) % 2 == 0) ? 70 : 25;
        unlock_pct = ((k / 40) % 2 == 0) ? 15 : 60;
      end
      // Long receiver stall while the sender keeps offering.
      if (k == n_items / 3) rx_hold_cycles <= 80;
      // Sender pause until the block has delivered everything.
      if (k == (2 * n_items) / 3) wait_drained();
      roll = $urandom_range(99);
      if (roll < fill_pct) f = FUNC_ACQUIRE;
      else if (roll < fill_pct + unlock_pct) f = FUNC_UNLOCK;
      else if (roll < 95) f = FUNC_TRY_LOCK;
      else f = FUNC_NONE;
      send_op(f, pick_id());
    end
  endtask

  // Main sequence.
  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    m_tready       = 1'b0;
    tx_idle_pct    = 27;
    rx_idle_pct    = 64;
    rx_hold_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: free unlock, no-op, unknown holder, zero-ID waiter,
    // self-wait, and handoff in FIFO order.
    send_op(FUNC_UNLOCK, 8'h00);
    send_op(FUNC_NONE, 8'h00);
    send_op(FUNC_TRY_LOCK, 8'hFF);
    send_op(FUNC_TRY_LOCK, 8'h5A);
    send_op(FUNC_ACQUIRE, 8'h5A);
    send_op(FUNC_ACQUIRE, 8'h00);
    send_op(FUNC_UNLOCK, 8'hA5);
    send_op(FUNC_ACQUIRE, 8'h5A);
    send_op(FUNC_NONE, 8'hA5);
    send_op(FUNC_UNLOCK, 8'h00);
    send_op(FUNC_ACQUIRE, 8'h00);
    send_op(FUNC_UNLOCK, 8'h00);
    send_op(FUNC_UNLOCK, 8'h00);
    send_op(FUNC_UNLOCK, 8'h00);
    send_op(FUNC_ACQUIRE, 8'hFF);
    send_op(FUNC_ACQUIRE, 8'hFF);
    send_op(FUNC_UNLOCK, 8'h01);
    send_op(FUNC_UNLOCK, 8'h80);

    // Random traffic under three idling patterns.
    run_phase(PHASE_ITEMS);
    tx_idle_pct = 64;
    rx_idle_pct = 27;
    run_phase(PHASE_ITEMS);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(PHASE_ITEMS);

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
